>>> hw/rtl/uks_pkg.sv
// Shared constants and types for the unbounded knapsack solver unit.
// No dependencies; every other file of the block but uks_ram imports this package.
package uks_pkg;

    localparam int MAX_CAPACITY = 1023;
    localparam int DEPTH        = MAX_CAPACITY + 1;
    localparam int IDX_W        = $clog2(DEPTH);

    localparam int VALUE_W  = 16;
    localparam int WEIGHT_W = 10;
    localparam int CAP_W    = 10;
    localparam int BEST_W   = 32;
    localparam int CMP_W    = (IDX_W > WEIGHT_W) ? IDX_W : WEIGHT_W;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_CAPACITY = REG_IDX_W'(0);

    typedef struct packed {
        logic              load;
        logic [BEST_W-1:0] value;
    } t_answer;

endpackage

>>> hw/rtl/uks_ram.sv
// Generic synchronous RAM with one write port and two registered read ports.
// Read-first behavior on a same-address read and write; no dependencies.
module uks_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic [WIDTH-1:0]         o_rdata_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

>>> hw/rtl/uks_apb_regs.sv
// APB-style configuration register file holding the knapsack capacity.
// Depends on uks_pkg for address and data widths.
module uks_apb_regs
    import uks_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [CAP_W-1:0]      o_capacity
);

    logic [CAP_W-1:0]     r_capacity;
    logic [CAP_W-1:0]     n_capacity;
    logic [REG_IDX_W-1:0] w_reg_idx;

    assign w_reg_idx = paddr[APB_ADDR_W-1:2];
    assign pready    = 1'b1;

    always_comb begin
        n_capacity = r_capacity;
        if (psel && penable && pwrite && pready && (w_reg_idx == REG_CAPACITY)) begin
            n_capacity = pwdata[CAP_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (w_reg_idx == REG_CAPACITY) begin
            prdata = APB_DATA_W'(r_capacity);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= '0;
        end else begin
            r_capacity <= n_capacity;
        end
    end

    assign o_capacity = r_capacity;

endmodule

>>> hw/rtl/uks_sweep.sv
// Table sweep engine: read-modify-write of the best-value RAM, answer read, clear pass.
// Depends on uks_pkg and instantiates uks_ram.
module uks_sweep
    import uks_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [VALUE_W-1:0]  i_item_value,
    input  logic [WEIGHT_W-1:0] i_item_weight,
    input  logic                i_last_item,
    input  logic [CAP_W-1:0]    i_capacity,
    input  logic                i_out_busy,
    output t_answer             o_answer
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SWEEP,
        S_DRAIN,
        S_ANS_RD,
        S_ANS_CAP
    } t_state;

    localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(MAX_CAPACITY);

    function automatic logic [BEST_W-1:0] sat_add(input logic [BEST_W-1:0] a,
                                                  input logic [BEST_W-1:0] b);
        logic [BEST_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[BEST_W] ? {BEST_W{1'b1}} : s[BEST_W-1:0];
    endfunction

    t_state              r_state, n_state;
    logic [IDX_W-1:0]    r_j, n_j;
    logic [IDX_W-1:0]    r_w, n_w;
    logic [VALUE_W-1:0]  r_value, n_value;
    logic                r_last, n_last;
    logic                r_p_valid, n_p_valid;
    logic [IDX_W-1:0]    r_p_addr, n_p_addr;
    logic                r_fwd_hit, n_fwd_hit;
    logic [BEST_W-1:0]   r_fwd_data, n_fwd_data;

    logic                w_accept;
    logic                w_skip;
    logic [IDX_W-1:0]    w_cap_idx;
    logic                w_we;
    logic [IDX_W-1:0]    w_waddr;
    logic [BEST_W-1:0]   w_wdata;
    logic [IDX_W-1:0]    w_raddr_a;
    logic [IDX_W-1:0]    w_raddr_b;
    logic [BEST_W-1:0]   w_rdata_a;
    logic [BEST_W-1:0]   w_rdata_b;
    logic [BEST_W-1:0]   w_opb;
    logic [BEST_W-1:0]   w_cand;

    uks_ram #(
        .WIDTH (BEST_W),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_raddr_a),
        .o_rdata_a (w_rdata_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_b (w_rdata_b)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_skip     = (i_item_weight == '0) ||
                        (CMP_W'(i_item_weight) > CMP_W'(MAX_CAPACITY));
    assign w_cap_idx  = (CMP_W'(i_capacity) > CMP_W'(MAX_CAPACITY)) ?
                        MAX_IDX : IDX_W'(i_capacity);

    // The entry j - w written in the previous cycle is still in flight in the RAM.
    assign w_opb  = r_fwd_hit ? r_fwd_data : w_rdata_b;
    assign w_cand = sat_add(BEST_W'(r_value), w_opb);

    always_comb begin
        w_we      = 1'b0;
        w_waddr   = r_p_addr;
        w_wdata   = (w_cand > w_rdata_a) ? w_cand : w_rdata_a;
        w_raddr_a = r_j;
        w_raddr_b = r_j - r_w;
        if (r_p_valid) begin
            w_we = 1'b1;
        end else if (r_state == S_CLEAR) begin
            w_we    = 1'b1;
            w_waddr = r_j;
            w_wdata = '0;
        end
        if (r_state == S_ANS_RD) begin
            w_raddr_a = w_cap_idx;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_j        = r_j;
        n_w        = r_w;
        n_value    = r_value;
        n_last     = r_last;
        n_p_valid  = 1'b0;
        n_p_addr   = r_j;
        n_fwd_hit  = w_we && (w_raddr_b == w_waddr);
        n_fwd_data = w_wdata;
        o_answer.load  = 1'b0;
        o_answer.value = w_rdata_a;
        unique case (r_state)
            S_CLEAR: begin
                if (r_j == MAX_IDX) begin
                    n_state = S_IDLE;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_value = i_item_value;
                    n_w     = IDX_W'(i_item_weight);
                    n_j     = IDX_W'(i_item_weight);
                    n_last  = i_last_item;
                    n_state = w_skip ? S_ANS_RD : S_SWEEP;
                end
            end
            S_SWEEP: begin
                n_p_valid = 1'b1;
                if (r_j == MAX_IDX) begin
                    n_state = S_DRAIN;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            S_DRAIN: begin
                n_state = S_ANS_RD;
            end
            S_ANS_RD: begin
                if (!r_last) begin
                    n_state = S_IDLE;
                end else if (!i_out_busy) begin
                    n_state = S_ANS_CAP;
                end
            end
            S_ANS_CAP: begin
                o_answer.load = 1'b1;
                n_j           = '0;
                n_state       = S_CLEAR;
            end
            default: begin
                n_state = S_CLEAR;
                n_j     = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_j       <= '0;
            r_p_valid <= 1'b0;
            r_fwd_hit <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_j       <= n_j;
            r_p_valid <= n_p_valid;
            r_fwd_hit <= n_fwd_hit;
        end
        r_w        <= n_w;
        r_value    <= n_value;
        r_last     <= n_last;
        r_p_addr   <= n_p_addr;
        r_fwd_data <= n_fwd_data;
    end

endmodule

>>> hw/rtl/unbounded_knapsack_solver_unit.sv
// Top level of the unbounded knapsack solver: config registers, sweep engine, output word.
// Depends on uks_pkg, uks_apb_regs, uks_sweep and, through it, uks_ram.
//
//   channel  direction  handshake                payload
//   in       input      i_in_valid / o_in_stall  i_item_value, i_item_weight, i_last_item
//   out      output     o_out_valid / i_out_stall o_best_value
//   cfg      input      APB psel/penable/pwrite  paddr, pwdata, prdata (capacity at 0)
//
// An item of weight w in 1..1023 sweeps entries w..1023, drains, then reads the answer
// entry; a zero weight only reads it. The single table RAM port pair, one entry per cycle,
// paces the sweep. A last item captures the answer once no result word is pending, then
// clears the table; the same clearing pass runs after reset before any item is taken.
// A stalled result word waits in the output register while new items are accepted;
// only the next answer waits for it to leave.
module unbounded_knapsack_solver_unit
    import uks_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [VALUE_W-1:0]    i_item_value,
    input  logic [WEIGHT_W-1:0]   i_item_weight,
    input  logic                  i_last_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [BEST_W-1:0]     o_best_value,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [CAP_W-1:0]  w_capacity;
    t_answer           w_answer;
    logic              r_out_valid, n_out_valid;
    logic [BEST_W-1:0] r_best, n_best;

    uks_apb_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_capacity (w_capacity)
    );

    uks_sweep u_sweep (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_item_value  (i_item_value),
        .i_item_weight (i_item_weight),
        .i_last_item   (i_last_item),
        .i_capacity    (w_capacity),
        .i_out_busy    (r_out_valid),
        .o_answer      (w_answer)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        n_best      = r_best;
        if (w_answer.load) begin
            n_out_valid = 1'b1;
            n_best      = w_answer.value;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
        r_best <= n_best;
    end

    assign o_out_valid  = r_out_valid;
    assign o_best_value = r_best;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_answer.load && r_out_valid))
        else $error("answer loaded over a pending result word");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input word accepted on consecutive cycles");

    a_clear_after_reset: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> o_in_stall)
        else $error("input accepted before the clearing pass");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_answer.load |=> (o_out_valid && o_best_value == $past(w_answer.value)))
        else $error("answer did not reach the output register");
`endif

endmodule

>>> tb/sv/tb.sv
// Testbench for unbounded_knapsack_solver_unit: a scoreboard class predicts each answer word.
// Plain tasks drive the item and APB ports. Depends on uks_pkg and the RTL of the unit.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import uks_pkg::*;

    localparam int PERIOD      = 10;
    localparam int ITEM_TARGET = 580;
    localparam int PHASE_ITEMS = 80;
    localparam int DRAIN       = 2200;
    localparam int HOLD_CYCLES = 5000;
    localparam int QUIET_LIMIT = 40000;
    localparam int IDLE_PCT    = 24;

    class knapsack_checker;
        bit [BEST_W-1:0] best_at_cap [DEPTH];
        bit [CAP_W-1:0]  capacity;
        bit [BEST_W-1:0] pending_best [$];
        int              errors;

        function new();
            clear_table();
            capacity = '0;
            errors   = 0;
        endfunction

        function void clear_table();
            foreach (best_at_cap[k]) best_at_cap[k] = '0;
        endfunction

        function void take_item(bit [VALUE_W-1:0] value, bit [WEIGHT_W-1:0] weight, bit last);
            bit [BEST_W:0] cand;
            int            j;
            int            idx;
            if (weight != 0) begin
                for (j = weight; j <= MAX_CAPACITY; j++) begin
                    cand = {1'b0, best_at_cap[j - weight]} + value;
                    if (cand[BEST_W]) begin
                        cand = {1'b0, {BEST_W{1'b1}}};
                    end
                    if (cand[BEST_W-1:0] > best_at_cap[j]) begin
                        best_at_cap[j] = cand[BEST_W-1:0];
                    end
                end
            end
            if (last) begin
                idx = (capacity > MAX_CAPACITY) ? MAX_CAPACITY : capacity;
                pending_best.push_back(best_at_cap[idx]);
                clear_table();
            end
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task match_answer(bit [BEST_W-1:0] got);
            bit [BEST_W-1:0] want;
            if (pending_best.size() == 0) begin
                report($sformatf("unexpected best_value %0d", got));
            end else begin
                want = pending_best.pop_front();
                if (got !== want) begin
                    report($sformatf("best_value got %0d, expected %0d", got, want));
                end
            end
        endtask
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [VALUE_W-1:0]    i_item_value;
    logic [WEIGHT_W-1:0]   i_item_weight;
    logic                  i_last_item;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [BEST_W-1:0]     o_best_value;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    knapsack_checker board = new();
    bit              calm = 1'b0;
    int              hold_req = 0;
    int              hold_seen = 0;
    int              hold_left = 0;
    int              counted_items = 0;
    int unsigned     quiet_cycles = 0;

    unbounded_knapsack_solver_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_item_value  (i_item_value),
        .i_item_weight (i_item_weight),
        .i_last_item   (i_last_item),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_best_value  (o_best_value),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #(PERIOD / 2) i_clk = ~i_clk;

    task automatic send_item(input logic [VALUE_W-1:0] value, input logic [WEIGHT_W-1:0] weight,
                             input logic last);
        if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_in_valid    = 1'b1;
        i_item_value  = value;
        i_item_weight = weight;
        i_last_item   = last;
        do @(posedge i_clk); while (o_in_stall);
        board.take_item(value, weight, last);
        counted_items++;
        @(negedge i_clk);
    endtask

    // The block may still be sweeping or clearing after the last answer word, so wait it out.
    task automatic set_capacity(input int cap);
        i_in_valid = 1'b0;
        while (board.pending_best.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {REG_CAPACITY, 2'b00};
        pwdata  = APB_DATA_W'(cap);
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        board.capacity = CAP_W'(cap);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                i_out_stall = 1'b1;
                hold_left--;
            end else if (calm) begin
                i_out_stall = 1'b0;
            end else begin
                i_out_stall = ($urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            board.match_answer(o_best_value);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (psel && penable && pwrite && pready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[unbounded_knapsack_solver_unit] ERROR");
            $finish;
        end
    end

    initial begin
        int                  phase;
        int                  phase_start;
        int                  n;
        int                  k;
        int                  r;
        logic [WEIGHT_W-1:0] w;

        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_item_value  = '0;
        i_item_weight = '0;
        i_last_item   = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed problems: field extremes, zero weight, oversized weight, mid-problem change.
        set_capacity(MAX_CAPACITY);
        send_item(16'hFFFF, 10'd1, 1'b0);
        send_item(16'h0000, 10'd1023, 1'b0);
        send_item(16'h0005, 10'd0, 1'b1);
        send_item(16'h0000, 10'd0, 1'b1);
        send_item(16'h8000, 10'd512, 1'b0);
        send_item(16'h7FFF, 10'd511, 1'b1);
        send_item(16'hAAAA, 10'd341, 1'b0);
        send_item(16'h5555, 10'd682, 1'b1);
        set_capacity(0);
        send_item(16'hFFFF, 10'd1, 1'b1);
        set_capacity(MAX_CAPACITY - 1);
        send_item(16'hFFFF, 10'd1023, 1'b1);
        set_capacity(5);
        send_item(16'd7, 10'd3, 1'b0);
        set_capacity(9);
        send_item(16'd4, 10'd2, 1'b1);
        set_capacity(1);
        send_item(16'd100, 10'd1, 1'b0);
        send_item(16'd300, 10'd2, 1'b1);

        phase = 0;
        while (counted_items < ITEM_TARGET) begin
            case (phase % 6)
                0:       set_capacity(MAX_CAPACITY);
                1:       set_capacity($urandom_range(1, MAX_CAPACITY - 1));
                2:       set_capacity(0);
                3:       set_capacity($urandom_range(1, 64));
                4:       set_capacity($urandom_range(0, MAX_CAPACITY));
                default: set_capacity(1);
            endcase
            calm = (phase == 1);
            if (phase == 3) begin
                // Long output hold-off while short problems keep arriving.
                hold_req++;
                repeat (6) begin
                    send_item(VALUE_W'($urandom), WEIGHT_W'($urandom_range(1000, 1023)),
                              1'b1);
                end
            end
            phase_start = counted_items;
            while (counted_items - phase_start < PHASE_ITEMS && counted_items < ITEM_TARGET) begin
                n = $urandom_range(1, 6);
                for (k = 0; k < n; k++) begin
                    r = $urandom_range(0, 99);
                    if (r < 8) begin
                        w = '0;
                    end else if (r < 40) begin
                        w = WEIGHT_W'($urandom_range(1, 24));
                    end else if (r < 50) begin
                        w = WEIGHT_W'($urandom_range(1000, 1023));
                    end else begin
                        w = WEIGHT_W'($urandom_range(1, 1023));
                    end
                    send_item(VALUE_W'($urandom), w, (k == n - 1) || ($urandom_range(0, 99) < 4));
                end
            end
            phase++;
        end
        calm       = 1'b0;
        i_in_valid = 1'b0;

        while (board.pending_best.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("[unbounded_knapsack_solver_unit] OK");
        end else begin
            $display("[unbounded_knapsack_solver_unit] ERROR");
        end
        $finish;
    end
endmodule

>>> files.f
hw/rtl/uks_pkg.sv
hw/rtl/uks_ram.sv
hw/rtl/uks_apb_regs.sv
hw/rtl/uks_sweep.sv
hw/rtl/unbounded_knapsack_solver_unit.sv
tb/sv/tb.sv
